### src/bdte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_pkg: shared types and constants for the date-to-epoch unit
// Microcode word layout, datapath operation codes, control and status
// bundles, and the calendar helper functions.
// ----------------------------------------------------------------------------
package bdte_pkg;

	localparam int unsigned YEAR_W   = 8;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned OFFSET_W = 11;
	localparam int unsigned EPOCH_W  = 34;
	localparam int unsigned STEP_W   = 4;

	// Years since 1900 of the first counted year (1970).
	localparam logic [YEAR_W-1:0]  YEAR_BASE = 8'd70;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd2;

	// Microprogram addresses.
	localparam logic [STEP_W-1:0] STEP_INIT   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_YEARS  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_LEAP   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_MONTHS = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DAY    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_HOUR   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_MINUTE = 4'd6;
	localparam logic [STEP_W-1:0] STEP_SECOND = 4'd7;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd8;

	typedef enum logic [3:0] {
		ACC_HOLD   = 4'd0,
		ACC_CLEAR  = 4'd1,
		ACC_YEAR   = 4'd2,
		ACC_LEAP   = 4'd3,
		ACC_MONTH  = 4'd4,
		ACC_DAY    = 4'd5,
		ACC_HOUR   = 4'd6,
		ACC_MINUTE = 4'd7,
		ACC_SECOND = 4'd8
	} acc_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_BASE = 2'd1,
		CNT_ZERO = 2'd2,
		CNT_INC  = 2'd3
	} cnt_op_t;

	typedef enum logic [1:0] {
		COND_NEVER      = 2'd0,
		COND_YEARS_DONE = 2'd1,
		COND_MONTH_DONE = 2'd2
	} cond_t;

	typedef struct packed {
		acc_op_t           op;
		cnt_op_t           cnt_op;
		cond_t             cond;
		logic [STEP_W-1:0] taken_addr;
		logic [STEP_W-1:0] next_addr;
		logic              last;
	} ucode_t;

	typedef struct packed {
		logic    load;
		logic    exec;
		logic    emit;
		acc_op_t op;
		cnt_op_t cnt_op;
	} dp_ctl_t;

	typedef struct packed {
		logic years_done;
		logic month_done;
	} dp_stat_t;

	// Leap test on years since 1900. 1900 is a multiple of four, so the low
	// bits decide; 1900 and 2100 are century years that are not leap years.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		is_leap = (y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200);
	endfunction

	function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1:    month_days = 5'd28;
			4'd3,
			4'd5,
			4'd8,
			4'd10:   month_days = 5'd30;
			default: month_days = 5'd31;
		endcase
	endfunction

endpackage

### src/bdte_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_ucode_rom: microprogram store
// One control word per step address; the program walks the year loop,
// the month loop and the final multiply-add steps.
// ----------------------------------------------------------------------------
module bdte_ucode_rom (
	input  logic [bdte_pkg::STEP_W-1:0] addr,
	output bdte_pkg::ucode_t            word
);

	always_comb begin
		word = '{op: bdte_pkg::ACC_HOLD, cnt_op: bdte_pkg::CNT_HOLD,
			cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_EMIT,
			next_addr: bdte_pkg::STEP_EMIT, last: 1'b1};
		case (addr)
			bdte_pkg::STEP_INIT: begin
				word = '{op: bdte_pkg::ACC_CLEAR, cnt_op: bdte_pkg::CNT_BASE,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_YEARS,
					next_addr: bdte_pkg::STEP_YEARS, last: 1'b0};
			end
			bdte_pkg::STEP_YEARS: begin
				word = '{op: bdte_pkg::ACC_YEAR, cnt_op: bdte_pkg::CNT_INC,
					cond: bdte_pkg::COND_YEARS_DONE, taken_addr: bdte_pkg::STEP_LEAP,
					next_addr: bdte_pkg::STEP_YEARS, last: 1'b0};
			end
			bdte_pkg::STEP_LEAP: begin
				word = '{op: bdte_pkg::ACC_LEAP, cnt_op: bdte_pkg::CNT_ZERO,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_MONTHS,
					next_addr: bdte_pkg::STEP_MONTHS, last: 1'b0};
			end
			bdte_pkg::STEP_MONTHS: begin
				word = '{op: bdte_pkg::ACC_MONTH, cnt_op: bdte_pkg::CNT_INC,
					cond: bdte_pkg::COND_MONTH_DONE, taken_addr: bdte_pkg::STEP_DAY,
					next_addr: bdte_pkg::STEP_MONTHS, last: 1'b0};
			end
			bdte_pkg::STEP_DAY: begin
				word = '{op: bdte_pkg::ACC_DAY, cnt_op: bdte_pkg::CNT_HOLD,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_HOUR,
					next_addr: bdte_pkg::STEP_HOUR, last: 1'b0};
			end
			bdte_pkg::STEP_HOUR: begin
				word = '{op: bdte_pkg::ACC_HOUR, cnt_op: bdte_pkg::CNT_HOLD,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_MINUTE,
					next_addr: bdte_pkg::STEP_MINUTE, last: 1'b0};
			end
			bdte_pkg::STEP_MINUTE: begin
				word = '{op: bdte_pkg::ACC_MINUTE, cnt_op: bdte_pkg::CNT_HOLD,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_SECOND,
					next_addr: bdte_pkg::STEP_SECOND, last: 1'b0};
			end
			bdte_pkg::STEP_SECOND: begin
				word = '{op: bdte_pkg::ACC_SECOND, cnt_op: bdte_pkg::CNT_HOLD,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_EMIT,
					next_addr: bdte_pkg::STEP_EMIT, last: 1'b0};
			end
			default: begin
				// The emit step, and any unused address, waits to hand off.
				word = '{op: bdte_pkg::ACC_HOLD, cnt_op: bdte_pkg::CNT_HOLD,
					cond: bdte_pkg::COND_NEVER, taken_addr: bdte_pkg::STEP_EMIT,
					next_addr: bdte_pkg::STEP_EMIT, last: 1'b1};
			end
		endcase
	end

endmodule

### src/bdte_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_sequencer: step counter and branch logic
// Fetches the control word for the current step, resolves conditional
// jumps against datapath status and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bdte_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  bdte_pkg::dp_stat_t stat,
	output bdte_pkg::dp_ctl_t  ctl
);

	logic                        busy_q;
	logic                        out_valid_q;
	logic [bdte_pkg::STEP_W-1:0] step_q;
	bdte_pkg::ucode_t            word;
	logic                        taken;
	logic                        accept;
	logic                        out_free;

	bdte_ucode_rom u_rom (
		.addr (step_q),
		.word (word)
	);

	always_comb begin
		case (word.cond)
			bdte_pkg::COND_YEARS_DONE: taken = stat.years_done;
			bdte_pkg::COND_MONTH_DONE: taken = stat.month_done;
			default:                   taken = 1'b0;
		endcase
	end

	assign accept   = in_valid && !busy_q;
	assign out_free = !out_valid_q || !out_stall;

	// A taken branch skips the step's operation; the loop exits that way.
	assign ctl.load   = accept;
	assign ctl.exec   = busy_q && !taken && !word.last;
	assign ctl.emit   = busy_q && word.last && out_free;
	assign ctl.op     = word.op;
	assign ctl.cnt_op = word.cnt_op;

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= bdte_pkg::STEP_INIT;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= bdte_pkg::STEP_INIT;
			end else if (busy_q) begin
				if (word.last) begin
					if (out_free) begin
						busy_q <= 1'b0;
					end
				end else if (taken) begin
					step_q <= word.taken_addr;
				end else begin
					step_q <= word.next_addr;
				end
			end

			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### src/bdte_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdte_datapath: accumulator, loop counter and result register
// Holds the captured item, applies one accumulator operation per step and
// reports loop exit conditions back to the sequencer.
// ----------------------------------------------------------------------------
module bdte_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bdte_pkg::dp_ctl_t                    ctl,
	output bdte_pkg::dp_stat_t                   stat,
	input  logic [bdte_pkg::YEAR_W-1:0]          years_since_1900,
	input  logic [bdte_pkg::MONTH_W-1:0]         month_index,
	input  logic [bdte_pkg::DAY_W-1:0]           day_of_month,
	input  logic [bdte_pkg::HOUR_W-1:0]          hour_of_day,
	input  logic [bdte_pkg::MINUTE_W-1:0]        minute_of_hour,
	input  logic [bdte_pkg::SECOND_W-1:0]        second_of_minute,
	input  logic                                 dst_active,
	input  logic signed [bdte_pkg::OFFSET_W-1:0] offset,
	output logic signed [bdte_pkg::EPOCH_W-1:0]  epoch_seconds
);

	localparam int unsigned W = bdte_pkg::EPOCH_W;

	logic [bdte_pkg::YEAR_W-1:0]         year_q;
	logic [bdte_pkg::MONTH_W-1:0]        month_q;
	logic [bdte_pkg::DAY_W-1:0]          day_q;
	logic [bdte_pkg::HOUR_W-1:0]         hour_q;
	logic [bdte_pkg::MINUTE_W-1:0]       minute_q;
	logic [bdte_pkg::SECOND_W-1:0]       second_q;
	logic                                dst_q;
	logic [bdte_pkg::YEAR_W-1:0]         cnt_q;
	logic signed [W-1:0]                 acc_q;
	logic signed [W-1:0]                 epoch_q;
	logic signed [W-1:0]                 acc_d;
	logic signed [W-1:0]                 acc_x24;
	logic signed [W-1:0]                 acc_x60;
	logic [bdte_pkg::MONTH_W-1:0]        month_clamped;

	// Months past December count as December.
	assign month_clamped = (month_index > bdte_pkg::MONTH_MAX) ?
		bdte_pkg::MONTH_MAX : month_index;

	assign stat.years_done = (cnt_q >= year_q);
	assign stat.month_done = (cnt_q >= {{(bdte_pkg::YEAR_W - bdte_pkg::MONTH_W){1'b0}}, month_q});

	assign acc_x24 = (acc_q <<< 4) + (acc_q <<< 3);
	assign acc_x60 = (acc_q <<< 6) - (acc_q <<< 2);

	always_comb begin
		case (ctl.op)
			bdte_pkg::ACC_CLEAR: acc_d = '0;
			bdte_pkg::ACC_YEAR: begin
				acc_d = acc_q + (bdte_pkg::is_leap(cnt_q) ? W'(366) : W'(365));
			end
			bdte_pkg::ACC_LEAP: begin
				acc_d = acc_q + W'(bdte_pkg::is_leap(year_q) &&
					(month_q >= bdte_pkg::MONTH_MAR));
			end
			bdte_pkg::ACC_MONTH: begin
				acc_d = acc_q + W'(bdte_pkg::month_days(cnt_q[bdte_pkg::MONTH_W-1:0]));
			end
			bdte_pkg::ACC_DAY:  acc_d = acc_q + W'(day_q) - W'(1);
			bdte_pkg::ACC_HOUR: acc_d = acc_x24 + W'(hour_q) - W'(dst_q);
			bdte_pkg::ACC_MINUTE: begin
				acc_d = acc_x60 + W'(minute_q) + W'(offset);
			end
			bdte_pkg::ACC_SECOND: acc_d = acc_x60 + W'(second_q);
			default:              acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			year_q   <= years_since_1900;
			month_q  <= month_clamped;
			day_q    <= day_of_month;
			hour_q   <= hour_of_day;
			minute_q <= minute_of_hour;
			second_q <= second_of_minute;
			dst_q    <= dst_active;
		end
		if (ctl.exec) begin
			acc_q <= acc_d;
		end
		if (ctl.emit) begin
			epoch_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.exec) begin
			case (ctl.cnt_op)
				bdte_pkg::CNT_BASE: cnt_q <= bdte_pkg::YEAR_BASE;
				bdte_pkg::CNT_ZERO: cnt_q <= '0;
				bdte_pkg::CNT_INC:  cnt_q <= cnt_q + 1'b1;
				default:            cnt_q <= cnt_q;
			endcase
		end
	end

	assign epoch_seconds = epoch_q;

endmodule

### src/broken_down_time_to_epoch_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_unit: local calendar time to epoch seconds
// Converts a broken-down local date and time into signed seconds since
// 1970-01-01 00:00:00 GMT, using a microcoded sequencer over one accumulator.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction (in_valid high, in_stall low) carries one date and
// time. The unit then runs a short microprogram: one step per whole year
// from 1970 up to the given year, one step per earlier month of that year
// (month index capped at 11), and fixed steps for the leap day, the day of
// month and the hour, minute and second scaling, all on the shared
// accumulator.
// One item is worked on at a time: in_stall stays high while the program
// runs. The result sits in an output register, so the next item is accepted
// as soon as the result is handed there, even while out_stall holds it.
// If the receiver stalls while the output register is still full, the
// program waits in its final step and nothing is lost.
// The user must write the offset register via cfg_valid/cfg_ready only while
// the unit is idle; the unit does not enforce this. cfg_ready is always high.
// Reset zeroes the offset and empties the unit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module broken_down_time_to_epoch_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic signed [bdte_pkg::OFFSET_W-1:0] cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bdte_pkg::YEAR_W-1:0]          years_since_1900,
	input  logic [bdte_pkg::MONTH_W-1:0]         month_index,
	input  logic [bdte_pkg::DAY_W-1:0]           day_of_month,
	input  logic [bdte_pkg::HOUR_W-1:0]          hour_of_day,
	input  logic [bdte_pkg::MINUTE_W-1:0]        minute_of_hour,
	input  logic [bdte_pkg::SECOND_W-1:0]        second_of_minute,
	input  logic                                 dst_active,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [bdte_pkg::EPOCH_W-1:0]  epoch_seconds
);

	// Zone offset in minutes west of GMT; it is added once, in the minute
	// step, before the final scaling to seconds.
	logic signed [bdte_pkg::OFFSET_W-1:0] offset_q;
	bdte_pkg::dp_ctl_t                    ctl;
	bdte_pkg::dp_stat_t                   stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= cfg_data;
		end
	end

	// The sequencer steps through the microprogram and drives the
	// datapath with one control bundle per cycle.
	bdte_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	bdte_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.years_since_1900 (years_since_1900),
		.month_index      (month_index),
		.day_of_month     (day_of_month),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute),
		.dst_active       (dst_active),
		.offset           (offset_q),
		.epoch_seconds    (epoch_seconds)
	);

endmodule

### sim/broken_down_time_to_epoch_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broken_down_time_to_epoch_unit_tb: self-checking bench for the epoch unit
// Sends local calendar dates through the unit under several zone offsets.
// Directed dates come first, then random dates. A built-in calculator
// predicts the GMT epoch seconds of each accepted date, and every output
// transaction is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module broken_down_time_to_epoch_unit_tb;

	localparam int unsigned YEAR_W   = bdte_pkg::YEAR_W;
	localparam int unsigned MONTH_W  = bdte_pkg::MONTH_W;
	localparam int unsigned DAY_W    = bdte_pkg::DAY_W;
	localparam int unsigned HOUR_W   = bdte_pkg::HOUR_W;
	localparam int unsigned MINUTE_W = bdte_pkg::MINUTE_W;
	localparam int unsigned SECOND_W = bdte_pkg::SECOND_W;
	localparam int unsigned OFFSET_W = bdte_pkg::OFFSET_W;
	localparam int unsigned EPOCH_W  = bdte_pkg::EPOCH_W;

	localparam int unsigned RANDOM_DATES  = 1700;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned HOLD_CYCLES   = 2500;
	localparam int unsigned IDLE_PERCENT  = 35;
	localparam int          MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// One local date and time, laid out like the input ports of the unit.
	typedef struct packed {
		logic [YEAR_W-1:0]   years;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic                dst;
	} civil_time_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic signed [OFFSET_W-1:0] cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [EPOCH_W-1:0]  epoch_seconds;

	// Date currently offered on the input ports.
	civil_time_t on_offer = '0;

	// Dates waiting to be sent, and GMT seconds owed by the unit.
	civil_time_t       pending_dates [$];
	logic [EPOCH_W-1:0] owed_epochs  [$];

	// Zone offset as the bench believes the unit holds it.
	logic signed [OFFSET_W-1:0] zone_west = '0;

	// While set, neither side idles.
	bit steady = 1'b0;

	int unsigned failures     = 0;
	int unsigned results_seen = 0;

	broken_down_time_to_epoch_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.years_since_1900 (on_offer.years),
		.month_index      (on_offer.month),
		.day_of_month     (on_offer.day),
		.hour_of_day      (on_offer.hour),
		.minute_of_hour   (on_offer.minute),
		.second_of_minute (on_offer.second),
		.dst_active       (on_offer.dst),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.epoch_seconds    (epoch_seconds)
	);

	always #6 clk = ~clk;

	// Gregorian rule on the full year number.
	function automatic bit leap_year(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// GMT seconds since 1970 for a local date under a minutes-west offset.
	// Months past December count as December, years before 1970 add no whole
	// years, and every other field is used as given. The low 34 bits are kept.
	function automatic logic [EPOCH_W-1:0] gmt_seconds_of(input civil_time_t t,
			input logic signed [OFFSET_W-1:0] west);
		int unsigned full_year;
		int unsigned mon;
		longint      days;
		longint      total;
		full_year = 1900 + 32'(t.years);
		mon       = 32'((t.month > bdte_pkg::MONTH_MAX) ? bdte_pkg::MONTH_MAX : t.month);
		days      = 0;
		for (int unsigned y = 1970; y < full_year; y++)
			days += leap_year(y) ? 366 : 365;
		for (int unsigned m = 0; m < mon; m++)
			days += MONTH_LEN[m];
		if (leap_year(full_year) && mon >= 2)
			days += 1;
		days  += longint'(t.day) - 1;
		total  = 24 * days + longint'(t.hour) - longint'(t.dst);
		total  = 60 * total + longint'(t.minute) + longint'(west);
		total  = 60 * total + longint'(t.second);
		return total[EPOCH_W-1:0];
	endfunction

	function automatic civil_time_t civil(input int y, input int mo, input int d,
			input int h, input int mi, input int s, input bit dst);
		civil_time_t t;
		t.years  = YEAR_W'(y);
		t.month  = MONTH_W'(mo);
		t.day    = DAY_W'(d);
		t.hour   = HOUR_W'(h);
		t.minute = MINUTE_W'(mi);
		t.second = SECOND_W'(s);
		t.dst    = dst;
		return t;
	endfunction

	// Mostly ordinary dates in the supported span; some raw bit patterns so
	// that every field bit and every out-of-range value gets exercised.
	function automatic civil_time_t random_date();
		civil_time_t t;
		logic [63:0] raw;
		if ($urandom_range(99) < 15) begin
			raw = {$urandom, $urandom};
			t   = raw[$bits(civil_time_t)-1:0];
		end else begin
			t = civil($urandom_range(205, 70), $urandom_range(11, 0), $urandom_range(31, 1),
				$urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(60, 0),
				1'($urandom_range(1)));
		end
		return t;
	endfunction

	function automatic bit take_a_break();
		return !steady && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	// Sender. A date stays on the ports until the unit takes it; each taken
	// date is priced right away, since the offset only changes while idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			on_offer <= '0;
		end else begin
			if (in_valid && !in_stall)
				owed_epochs.push_back(gmt_seconds_of(on_offer, zone_west));
			if (!in_valid || !in_stall) begin
				if (pending_dates.size() != 0 && !take_a_break()) begin
					on_offer <= pending_dates.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Checks each output transaction against the oldest owed value.
	// Once, after a few hundred results, it holds off for a long stretch so
	// that the unit fills up and stalls the sender.
	int unsigned  hold_left = 0;
	bit           held_once = 1'b0;
	logic [EPOCH_W-1:0] owed;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (owed_epochs.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, epoch_seconds);
				end else begin
					owed = owed_epochs.pop_front();
					if (epoch_seconds !== owed) begin
						failures++;
						$display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
							$time, $signed(owed), epoch_seconds);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held_once && results_seen >= 400) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= take_a_break();
			end
		end
	end

	// Waits until every queued date has been taken and every result is in.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_dates.size() != 0 || in_valid || owed_epochs.size() != 0);
	endtask

	// Writes the zone offset; only called with the unit idle.
	task automatic set_zone(input logic signed [OFFSET_W-1:0] west);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= west;
		do
			@(posedge clk);
		while (!cfg_ready);
		zone_west = west;
		cfg_valid <= 1'b0;
	endtask

	int unsigned phase_count;
	logic signed [OFFSET_W-1:0] zone_plan [6];

	initial begin
		// The fourth entry is the most negative offset the register can hold.
		zone_plan = '{11'sd840, -11'sd840, 11'sd1023, 11'sh400, 11'sd0, '0};
		zone_plan[5] = OFFSET_W'($urandom_range(2047));
		phase_count  = 6;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed dates under the reset offset of zero.
		@(negedge clk);
		pending_dates.push_back(civil(70, 0, 1, 0, 0, 0, 0));     // the epoch itself
		pending_dates.push_back(civil(70, 0, 1, 0, 0, 0, 1));     // daylight saving at epoch
		pending_dates.push_back(civil(0, 0, 0, 0, 0, 0, 1));      // lowest value reachable
		pending_dates.push_back(civil(0, 5, 15, 12, 0, 0, 0));    // 1900, before 1970
		pending_dates.push_back(civil(69, 11, 31, 23, 59, 59, 0));
		pending_dates.push_back(civil(72, 1, 28, 12, 0, 0, 0));   // first leap year
		pending_dates.push_back(civil(72, 2, 1, 0, 0, 0, 0));
		pending_dates.push_back(civil(100, 1, 29, 0, 0, 0, 0));   // 2000 is leap, by 400
		pending_dates.push_back(civil(100, 2, 1, 0, 0, 0, 0));
		pending_dates.push_back(civil(101, 2, 1, 0, 0, 0, 0));    // plain common year
		pending_dates.push_back(civil(200, 2, 1, 0, 0, 0, 0));    // 2100 is not leap
		pending_dates.push_back(civil(104, 12, 31, 0, 0, 0, 0));  // month past December
		pending_dates.push_back(civil(104, 15, 1, 0, 0, 0, 0));
		pending_dates.push_back(civil(110, 3, 0, 0, 0, 0, 0));    // day zero
		pending_dates.push_back(civil(105, 11, 31, 23, 59, 60, 0)); // leap second
		pending_dates.push_back(civil(138, 0, 19, 3, 14, 8, 0));
		pending_dates.push_back(civil(120, 6, 4, 24, 60, 63, 0)); // time fields out of range
		pending_dates.push_back(civil(205, 11, 31, 23, 59, 59, 1));
		pending_dates.push_back(civil(255, 15, 31, 31, 63, 63, 1)); // every field at its top
		pending_dates.push_back(civil(255, 0, 1, 0, 0, 0, 0));
		wait_drained();

		// Random dates, spread over several zone offsets, extremes included.
		// The third phase runs without any idling on either side.
		for (int unsigned p = 0; p < phase_count; p++) begin
			set_zone(zone_plan[p]);
			@(negedge clk);
			steady = (p == 2);
			for (int unsigned i = 0; i < RANDOM_DATES / phase_count; i++)
				pending_dates.push_back(random_date());
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("broken_down_time_to_epoch_unit verification clean");
		end else begin
			$display("broken_down_time_to_epoch_unit verification failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#50_000_000;
		$display("broken_down_time_to_epoch_unit verification failed");
		$finish;
	end

endmodule

### broken_down_time_to_epoch_unit.f
src/bdte_pkg.sv
src/bdte_ucode_rom.sv
src/bdte_sequencer.sv
src/bdte_datapath.sv
src/broken_down_time_to_epoch_unit.sv
sim/broken_down_time_to_epoch_unit_tb.sv
